>>> hw/rtl/single_cycle_permutation_builder_macros.svh
// assertion helpers for the permutation builder
`ifndef SINGLE_CYCLE_PERMUTATION_BUILDER_MACROS_SVH
`define SINGLE_CYCLE_PERMUTATION_BUILDER_MACROS_SVH

// implication checked every clock, off during reset
`define SCPB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication, consequent checked at the next clock
`define SCPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/scpb_pkg.sv
package scpb_pkg;

    localparam int MAX_LINES  = 32768;
    localparam int LINE_BYTES = 64;
    localparam int IDX_W      = $clog2(MAX_LINES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 48;
    localparam int RND_W      = 31;
    localparam int OFS_W      = $clog2(LINE_BYTES);

    localparam logic [1:0] REQ_INIT = 2'd0;
    localparam logic [1:0] REQ_STEP = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;
    localparam logic [1:0] REQ_NOP  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [0:0] REG_LINE_COUNT  = 1'd0;
    localparam logic [0:0] REG_REGION_BASE = 1'd1;

    // controller to datapath
    typedef struct packed {
        logic init_clr;   // clear fill index
        logic fill_wr;    // write fill index to store, advance
        logic div_start;  // load divider with random word; divisor is the step position
        logic div_step;   // one restoring divider step
        logic rd_a;       // read store at address a (i or pos)
        logic rd_b;       // read store at address b (j or next pos)
        logic cap_a;      // capture read data a
        logic cap_b;      // capture read data b
        logic wr_a;       // write captured b at address a
        logic wr_b;       // write captured a at address b
        logic step_dec;   // decrement step position
        logic set_init;   // load step position from count
        logic latch_req;  // take input item position
        logic sel_read;   // addresses a/b are pos/next pos instead of i/j
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fill_last;
        logic div_last;
        logic step_zero;
        logic done;
        logic pos_bad;
    } sts_t;

endpackage

>>> hw/rtl/single_cycle_permutation_builder.sv
// Sattolo shuffle engine over up to 32768 cache-line indices, held in an internal
// two-port memory. An init item writes the identity, one entry per cycle, over the
// clamped line count. A shuffle step runs a bit-serial remainder of the 31-bit
// random word by the step position and then a read, capture and write-back swap on
// both memory ports. A read item goes through the same ports and skips the read when
// the position is out of range; an ignored step or a request of type three goes
// straight to the result. One item is in work at a time; the result sits in an
// output register, so the next item is taken while it waits, and a further result
// stalls until the register is free.
// Reads of store entries never written by an init return undefined addresses.
module single_cycle_permutation_builder
(
    input  logic         clk,
    input  logic         rst_n,
    // slave item: [1:0] req_type, [32:2] random_word, [47:33] position
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,
    // master item: [47:0] line_address, [95:48] next_address,
    // [96] shuffle_done, [98:97] status, rest zero
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    scpb_pkg::cmd_t cmd;
    scpb_pkg::sts_t sts;

    logic [15:0]  line_count_reg;
    logic [47:0]  region_base_reg;
    logic         out_valid_reg;
    logic [103:0] out_data_reg;
    logic         res_load;
    logic [1:0]   res_status;
    logic         res_zero;
    logic [47:0]  addr_a, addr_b;
    logic         cfg_wr;
    logic [0:0]   reg_sel;

    // registers at 8-byte spacing since region_base is 48 bits
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[3:3];

    always_comb
    begin
        prdata = '0;
        if (paddr[2:0] == 3'd0)
        begin
            unique case (reg_sel)
                scpb_pkg::REG_LINE_COUNT:  prdata = {48'd0, line_count_reg};
                scpb_pkg::REG_REGION_BASE: prdata = {16'd0, region_base_reg};
                default:                   prdata = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg  <= 16'd32768;
            region_base_reg <= '0;
        end
        else if (cfg_wr && paddr[2:0] == 3'd0)
        begin
            if (reg_sel == scpb_pkg::REG_LINE_COUNT)
                line_count_reg <= pwdata[15:0];
            else
                region_base_reg <= pwdata[47:0];
        end
    end

    scpb_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_req        (s_tdata[1:0]),
        .in_ready      (s_tready),
        .res_load      (res_load),
        .res_status    (res_status),
        .res_zero_addr (res_zero),
        .res_free      (!out_valid_reg || m_tready),
        .cmd           (cmd),
        .sts           (sts)
    );

    scpb_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_random_word (s_tdata[32:2]),
        .in_position    (s_tdata[47:33]),
        .line_count     (line_count_reg),
        .region_base    (region_base_reg),
        .zero_addr      (res_zero),
        .addr_a         (addr_a),
        .addr_b         (addr_b)
    );

    // output register, done flag sampled after the item's update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            out_data_reg <= {5'd0, res_status, sts.done, addr_b, addr_a};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> hw/rtl/scpb_ctrl.sv
`include "single_cycle_permutation_builder_macros.svh"

module scpb_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_req,
    output logic                in_ready,
    output logic                res_load,
    output logic [1:0]          res_status,
    output logic                res_zero_addr,
    input  logic                res_free,
    output scpb_pkg::cmd_t      cmd,
    input  scpb_pkg::sts_t      sts
);

    typedef enum logic [3:0] {
        S_IDLE, S_FILL, S_DIV, S_SW_RD, S_SW_CAP, S_SW_WR, S_RD_RD, S_RD_CAP, S_RESULT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic       zero_reg, zero_next;

    assign in_ready      = (state_reg == S_IDLE);
    assign res_status    = status_reg;
    assign res_zero_addr = zero_reg;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        zero_next   = zero_reg;
        cmd         = '0;
        res_load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_req = 1'b1;
                    status_next   = scpb_pkg::ST_OK;
                    zero_next     = 1'b1;
                    state_next    = S_RESULT;
                    if (in_req == scpb_pkg::REQ_INIT)
                    begin
                        cmd.init_clr = 1'b1;
                        state_next   = S_FILL;
                    end
                    else if (in_req == scpb_pkg::REQ_STEP)
                    begin
                        if (sts.done || sts.step_zero)
                        begin
                            status_next = scpb_pkg::ST_DONE;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    else if (in_req == scpb_pkg::REQ_READ)
                    begin
                        state_next = S_RD_RD;
                    end
                end
            end
            S_FILL:
            begin
                cmd.fill_wr = 1'b1;
                if (sts.fill_last)
                begin
                    cmd.set_init = 1'b1;
                    state_next   = S_RESULT;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_SW_RD;
                end
            end
            S_SW_RD:
            begin
                cmd.rd_a   = 1'b1;
                cmd.rd_b   = 1'b1;
                state_next = S_SW_CAP;
            end
            S_SW_CAP:
            begin
                cmd.cap_a  = 1'b1;
                cmd.cap_b  = 1'b1;
                state_next = S_SW_WR;
            end
            S_SW_WR:
            begin
                cmd.wr_a     = 1'b1;
                cmd.wr_b     = 1'b1;
                cmd.step_dec = 1'b1;
                state_next   = S_RESULT;
            end
            S_RD_RD:
            begin
                cmd.sel_read = 1'b1;
                if (sts.pos_bad)
                begin
                    status_next = scpb_pkg::ST_RANGE;
                    state_next  = S_RESULT;
                end
                else
                begin
                    cmd.rd_a   = 1'b1;
                    cmd.rd_b   = 1'b1;
                    state_next = S_RD_CAP;
                end
            end
            S_RD_CAP:
            begin
                cmd.sel_read = 1'b1;
                cmd.cap_a    = 1'b1;
                cmd.cap_b    = 1'b1;
                zero_next    = 1'b0;
                state_next   = S_RESULT;
            end
            S_RESULT:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= scpb_pkg::ST_OK;
            zero_reg   <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            zero_reg   <= zero_next;
        end
    end

    `SCPB_ASSERT_IMPL(a_swap_both, cmd.wr_a, cmd.wr_b && cmd.step_dec, "swap writes split")
    `SCPB_ASSERT_NEXT(a_rd_then_cap, state_reg == S_SW_RD, state_reg == S_SW_CAP,
        "swap read not followed by capture")
    `SCPB_ASSERT_IMPL(a_range_zero, res_load && status_reg == scpb_pkg::ST_RANGE, zero_reg,
        "out of range read with address")

endmodule

>>> hw/rtl/scpb_datapath.sv
`include "single_cycle_permutation_builder_macros.svh"

module scpb_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  scpb_pkg::cmd_t                      cmd,
    output scpb_pkg::sts_t                      sts,
    input  logic [scpb_pkg::RND_W-1:0]          in_random_word,
    input  logic [scpb_pkg::IDX_W-1:0]          in_position,
    input  logic [15:0]                         line_count,
    input  logic [scpb_pkg::ADDR_W-1:0]         region_base,
    input  logic                                zero_addr,
    output logic [scpb_pkg::ADDR_W-1:0]         addr_a,
    output logic [scpb_pkg::ADDR_W-1:0]         addr_b
);

    localparam int IW = scpb_pkg::IDX_W;
    localparam int CW = scpb_pkg::CNT_W;
    localparam int RW = scpb_pkg::RND_W;
    localparam int DC_W = $clog2(RW + 1);

    logic [IW-1:0] mem [scpb_pkg::MAX_LINES];

    logic [IW-1:0] step_reg;
    logic          done_reg;
    logic [CW-1:0] fill_reg;
    logic [IW-1:0] pos_reg;
    logic [RW-1:0] quo_reg;      // dividend shifts out here
    logic [IW-1:0] rem_reg;
    logic [DC_W-1:0] dcnt_reg;
    logic [IW-1:0] rda_reg, rdb_reg, cpa_reg, cpb_reg;

    logic [CW-1:0] n_eff;
    logic [IW:0]   trial;
    logic [IW-1:0] next_pos;
    logic [IW-1:0] adr_a, adr_b;
    logic [scpb_pkg::ADDR_W-1:0] base_al;

    // clamp count into [2, max]
    always_comb
    begin
        if (line_count < 16'd2)
            n_eff = CW'(2);
        else if (32'(line_count) > 32'(scpb_pkg::MAX_LINES))
            n_eff = CW'(scpb_pkg::MAX_LINES);
        else
            n_eff = CW'(line_count);
    end

    assign next_pos = (CW'(pos_reg) + CW'(1) >= n_eff) ? '0 : IW'(CW'(pos_reg) + CW'(1));
    assign adr_a    = cmd.sel_read ? pos_reg : step_reg;
    assign adr_b    = cmd.sel_read ? next_pos : rem_reg;
    assign trial    = {rem_reg, quo_reg[RW-1]} - {1'b0, step_reg};

    assign sts.fill_last = (fill_reg + CW'(1) == n_eff);
    assign sts.div_last  = (dcnt_reg == DC_W'(1));
    assign sts.step_zero = (step_reg == '0);
    assign sts.done      = done_reg;
    assign sts.pos_bad   = (CW'(pos_reg) >= n_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b1;
            fill_reg <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            if (cmd.init_clr)
                fill_reg <= '0;
            else if (cmd.fill_wr)
                fill_reg <= fill_reg + CW'(1);
            if (cmd.set_init)
            begin
                step_reg <= IW'(n_eff - CW'(1));
                done_reg <= (IW'(n_eff - CW'(1)) == '0);
            end
            else if (cmd.latch_req && !cmd.div_start && !cmd.init_clr && sts.step_zero)
            begin
                done_reg <= done_reg | (step_reg == '0);
            end
            else if (cmd.step_dec)
            begin
                step_reg <= step_reg - IW'(1);
                if (step_reg == IW'(1))
                    done_reg <= 1'b1;
            end
            if (cmd.div_start)
                dcnt_reg <= DC_W'(RW);
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg - DC_W'(1);
        end
    end

    // restoring remainder, one dividend bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
            pos_reg <= in_position;
        if (cmd.div_start)
        begin
            quo_reg <= in_random_word;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[RW-2:0], 1'b0};
            if (!trial[IW])
                rem_reg <= trial[IW-1:0];
            else
                rem_reg <= {rem_reg[IW-2:0], quo_reg[RW-1]};
        end
    end

    // permutation store, two ports
    always_ff @(posedge clk)
    begin
        if (cmd.fill_wr)
            mem[fill_reg[IW-1:0]] <= fill_reg[IW-1:0];
        if (cmd.wr_a)
            mem[step_reg] <= cpb_reg;
        if (cmd.wr_b)
            mem[rem_reg] <= cpa_reg;
        if (cmd.rd_a)
            rda_reg <= mem[adr_a];
        if (cmd.rd_b)
            rdb_reg <= mem[adr_b];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_a)
            cpa_reg <= rda_reg;
        if (cmd.cap_b)
            cpb_reg <= rdb_reg;
    end

    assign base_al = {region_base[scpb_pkg::ADDR_W-1:scpb_pkg::OFS_W], scpb_pkg::OFS_W'(0)};
    assign addr_a  = zero_addr ? '0 :
        base_al + (scpb_pkg::ADDR_W'(cpa_reg) << scpb_pkg::OFS_W);
    assign addr_b  = zero_addr ? '0 :
        base_al + (scpb_pkg::ADDR_W'(cpb_reg) << scpb_pkg::OFS_W);

    `SCPB_ASSERT_IMPL(a_div_nonzero, cmd.div_start, step_reg != '0, "divide by zero position")
    `SCPB_ASSERT_IMPL(a_rem_range, cmd.wr_b, rem_reg < step_reg, "swap index not below step")
    `SCPB_ASSERT_NEXT(a_step_done, cmd.step_dec && step_reg == IW'(1), done_reg,
        "done not set at end of shuffle")

endmodule
